/* src/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_WIDTH_DEF = 8;

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_GT         = 5'd4,
    OP_LT         = 5'd5,
    OP_GE         = 5'd6,
    OP_LE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_TO_INT     = 5'd15,
    OP_FROM_FLOAT = 5'd16,
    OP_TO_FLOAT   = 5'd17
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_FLOAT   = 2'd2
  } st_t;

endpackage

/* src/fpa_if.sv */
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channels for the fixed-point ALU: operations in, results out.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        condition;
  logic [1:0]  status;

  modport source (output valid, result_word, condition, status, input ready);
  modport sink   (input valid, result_word, condition, status, output ready);
endinterface

/* src/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Stateless signed 32-bit fixed-point ALU, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, in order. A new operation can be
// taken every cycle while the pipeline is not frozen; the block holds up to
// one item per stage. The path from input acceptance to result valid is the
// same for every operation: it is set by the divider, which resolves two
// quotient bits per stage. All other operations ride alongside in a matching
// delay line. The whole pipeline moves together and freezes while a finished
// result waits on out_chan.ready.
module fixed_point_alu #(
  parameter int FRAC_WIDTH = fpa_pkg::FRAC_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fpa_in_if.sink           in_chan,
  fpa_out_if.source        out_chan
);

  localparam int NS  = (32 + FRAC_WIDTH + 1) / 2;   // divider iteration stages
  localparam int TOP = NS + 3;                      // last stage before output

  typedef struct packed {
    logic            vld;
    fpa_pkg::op_t    op;
    logic [31:0]     word;
    logic            cond;
    fpa_pkg::st_t    status;
  } pipe_t;

  // global advance: every stage moves when the output slot is free or taken
  logic adv;

  // stage 1: input register
  logic               v1_r;
  fpa_pkg::op_t       op1_r;
  logic signed [31:0] a1_r;
  logic signed [31:0] b1_r;

  pipe_t              pl_r  [2:TOP];
  pipe_t              pl_in [2:TOP];
  logic signed [63:0] prod2_r;

  logic [31:0] div_q;
  logic [31:0] ff_word;
  logic        ff_bad;
  logic [31:0] tf_word;

  logic        out_vld_r;
  logic [31:0] out_word_r;
  logic        out_cond_r;
  logic [1:0]  out_st_r;

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= fpa_pkg::op_t'(in_chan.action);
      a1_r  <= in_chan.operand_a;
      b1_r  <= in_chan.operand_b;
    end
  end

  // shared units
  fpa_div #(.FRAC_WIDTH(FRAC_WIDTH)) u_div (
    .clk (clk),
    .en  (adv),
    .a   (a1_r),
    .b   (b1_r),
    .q   (div_q)
  );

  fpa_cvt #(.FRAC_WIDTH(FRAC_WIDTH)) u_cvt (
    .clk     (clk),
    .en      (adv),
    .a       (a1_r),
    .ff_word (ff_word),
    .ff_bad  (ff_bad),
    .tf_word (tf_word)
  );

  always_comb begin
    // stage 2: operations resolved directly from the input register
    pl_in[2].vld    = v1_r;
    pl_in[2].op     = op1_r;
    pl_in[2].word   = '0;
    pl_in[2].cond   = 1'b0;
    pl_in[2].status = fpa_pkg::ST_OK;
    case (op1_r)
      fpa_pkg::OP_ADD:      pl_in[2].word = 32'(a1_r + b1_r);
      fpa_pkg::OP_SUB:      pl_in[2].word = 32'(a1_r - b1_r);
      fpa_pkg::OP_DIV: begin
        if (b1_r == '0) pl_in[2].status = fpa_pkg::ST_DIVZERO;
      end
      fpa_pkg::OP_GT:       pl_in[2].cond = (a1_r > b1_r);
      fpa_pkg::OP_LT:       pl_in[2].cond = (a1_r < b1_r);
      fpa_pkg::OP_GE:       pl_in[2].cond = (a1_r >= b1_r);
      fpa_pkg::OP_LE:       pl_in[2].cond = (a1_r <= b1_r);
      fpa_pkg::OP_EQ:       pl_in[2].cond = (a1_r == b1_r);
      fpa_pkg::OP_NE:       pl_in[2].cond = (a1_r != b1_r);
      fpa_pkg::OP_MIN:      pl_in[2].word = (a1_r < b1_r) ? a1_r : b1_r;
      fpa_pkg::OP_MAX:      pl_in[2].word = (a1_r > b1_r) ? a1_r : b1_r;
      fpa_pkg::OP_INC:      pl_in[2].word = 32'(a1_r + 32'sd1);
      fpa_pkg::OP_DEC:      pl_in[2].word = 32'(a1_r - 32'sd1);
      fpa_pkg::OP_FROM_INT: pl_in[2].word = 32'(a1_r << FRAC_WIDTH);
      fpa_pkg::OP_TO_INT:   pl_in[2].word = 32'(a1_r >>> FRAC_WIDTH);
      default: ;
    endcase

    for (int k = 3; k <= TOP; k++) begin
      pl_in[k] = pl_r[k-1];
    end

    // stage 3: product scaled back to the fixed format
    if (pl_r[2].op == fpa_pkg::OP_MUL) begin
      pl_in[3].word = 32'(prod2_r >>> FRAC_WIDTH);
    end

    // stage 6: conversion results join the line
    if (pl_r[5].op == fpa_pkg::OP_FROM_FLOAT) begin
      pl_in[6].word   = ff_word;
      pl_in[6].status = ff_bad ? fpa_pkg::ST_FLOAT : fpa_pkg::ST_OK;
    end else if (pl_r[5].op == fpa_pkg::OP_TO_FLOAT) begin
      pl_in[6].word = tf_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 2; k <= TOP; k++) begin
        pl_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 2; k <= TOP; k++) begin
        pl_r[k] <= pl_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2_r <= a1_r * b1_r;
    end
  end

  // output register: quotient merges here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= pl_r[TOP].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= (pl_r[TOP].op == fpa_pkg::OP_DIV && pl_r[TOP].status == fpa_pkg::ST_OK)
                    ? div_q : pl_r[TOP].word;
      out_cond_r <= pl_r[TOP].cond;
      out_st_r   <= pl_r[TOP].status;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.result_word = out_word_r;
  assign out_chan.condition   = out_cond_r;
  assign out_chan.status      = out_st_r;

  // ---- checks
  a_cond_only_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (pl_r[TOP].vld && pl_r[TOP].cond) |->
      (pl_r[TOP].op == fpa_pkg::OP_GT || pl_r[TOP].op == fpa_pkg::OP_LT ||
       pl_r[TOP].op == fpa_pkg::OP_GE || pl_r[TOP].op == fpa_pkg::OP_LE ||
       pl_r[TOP].op == fpa_pkg::OP_EQ || pl_r[TOP].op == fpa_pkg::OP_NE))
    else $error("condition set on a non-compare operation");

  a_divzero_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pl_r[TOP].vld && pl_r[TOP].status == fpa_pkg::ST_DIVZERO) |->
      (pl_r[TOP].op == fpa_pkg::OP_DIV))
    else $error("divide-by-zero status on a non-divide operation");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> v1_r)
    else $error("accepted transaction not captured");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pl_r[TOP].vld) && out_vld_r)
    else $error("pipeline moved while stalled");

endmodule

/* src/fpa_div.sv */
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined signed restoring divider, (a << FRAC_WIDTH) / b, two quotient
// bits per stage, low 32 quotient bits kept, truncation toward zero.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int FRAC_WIDTH = fpa_pkg::FRAC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic [31:0]        q
);

  localparam int DW = 32 + FRAC_WIDTH;
  localparam int NS = (DW + 1) / 2;
  localparam int NW = NS * 2;

  logic [NW-1:0] num_r [NS+1];
  logic [32:0]   rem_r [NS+1];
  logic [31:0]   quo_r [NS+1];
  logic [31:0]   den_r [NS+1];
  logic          neg_r [NS+1];
  logic [31:0]   q_r;

  logic [31:0] a_mag;
  logic [31:0] b_mag;

  assign a_mag = a[31] ? 32'(-a) : 32'(a);
  assign b_mag = b[31] ? 32'(-b) : 32'(b);

  // operand preparation
  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= NW'(a_mag) << FRAC_WIDTH;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      den_r[0] <= b_mag;
      neg_r[0] <= a[31] ^ b[31];
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [NW-1:0] num_nxt;
    logic [32:0]   rem_nxt;
    logic [31:0]   quo_nxt;

    always_comb begin
      num_nxt = num_r[k-1];
      rem_nxt = rem_r[k-1];
      quo_nxt = quo_r[k-1];
      for (int s = 0; s < 2; s++) begin
        rem_nxt = {rem_nxt[31:0], num_nxt[NW-1]};
        num_nxt = num_nxt << 1;
        quo_nxt = {quo_nxt[30:0], 1'b0};
        if (rem_nxt >= {1'b0, den_r[k-1]}) begin
          rem_nxt    = rem_nxt - {1'b0, den_r[k-1]};
          quo_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_nxt;
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[NS] ? 32'(-quo_r[NS]) : quo_r[NS];
    end
  end

  assign q = q_r;

endmodule

/* src/fpa_cvt.sv */
// ----------------------------------------------------------------------------
// fpa_cvt
// Four-stage float conversions: IEEE single to fixed (half away from zero,
// saturating) and fixed to IEEE single (nearest even).
// ----------------------------------------------------------------------------
module fpa_cvt #(
  parameter int FRAC_WIDTH = fpa_pkg::FRAC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  output logic [31:0]        ff_word,
  output logic               ff_bad,
  output logic [31:0]        tf_word
);

  // ---- stage 1: decode
  logic signed [9:0] e_c;
  logic        ff_sgn1_r, ff_nan1_r, ff_big1_r, ff_zer1_r, ff_left1_r;
  logic [3:0]  ff_lsh1_r;
  logic [4:0]  ff_rsh1_r;
  logic [23:0] ff_sig1_r;
  logic        tf_sgn1_r;
  logic [31:0] tf_mag1_r;

  assign e_c = $signed({2'b00, a[30:23]}) - $signed(10'd150)
             + $signed(10'(FRAC_WIDTH));

  always_ff @(posedge clk) begin
    if (en) begin
      ff_sgn1_r  <= a[31];
      ff_nan1_r  <= (a[30:23] == 8'hFF) && (a[22:0] != '0);
      ff_big1_r  <= (a[30:23] == 8'hFF) || (e_c >= 10'sd9);
      ff_zer1_r  <= (a[30:23] == 8'h00) || (e_c <= -10'sd25);
      ff_left1_r <= (e_c >= 10'sd0);
      ff_lsh1_r  <= e_c[3:0];
      ff_rsh1_r  <= 5'(-e_c);
      ff_sig1_r  <= {1'b1, a[22:0]};
      tf_sgn1_r  <= a[31];
      tf_mag1_r  <= a[31] ? 32'(-a) : 32'(a);
    end
  end

  // ---- stage 2: align / find leading one
  logic [4:0]  p_c;
  logic        ff_sgn2_r, ff_nan2_r, ff_big2_r, ff_zer2_r, ff_left2_r;
  logic [32:0] ff_val2_r;
  logic        tf_sgn2_r, tf_zer2_r;
  logic [31:0] tf_mag2_r;
  logic [4:0]  tf_p2_r;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (tf_mag1_r[i]) p_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ff_sgn2_r  <= ff_sgn1_r;
      ff_nan2_r  <= ff_nan1_r;
      ff_big2_r  <= ff_big1_r;
      ff_zer2_r  <= ff_zer1_r;
      ff_left2_r <= ff_left1_r;
      if (ff_zer1_r) begin
        ff_val2_r <= '0;
      end else if (ff_left1_r) begin
        ff_val2_r <= 33'(ff_sig1_r) << ff_lsh1_r;
      end else begin
        ff_val2_r <= 33'({ff_sig1_r, 1'b0} >> ff_rsh1_r);
      end
      tf_sgn2_r <= tf_sgn1_r;
      tf_zer2_r <= (tf_mag1_r == '0);
      tf_mag2_r <= tf_mag1_r;
      tf_p2_r   <= p_c;
    end
  end

  // ---- stage 3: round / normalise
  logic        ff_sgn3_r, ff_nan3_r, ff_big3_r, ff_zer3_r;
  logic [32:0] ff_mag3_r;
  logic        tf_sgn3_r, tf_zer3_r;
  logic [31:0] tf_norm3_r;
  logic [4:0]  tf_p3_r;
  logic [32:0] ff_inc_c;

  assign ff_inc_c = ff_val2_r + 33'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      ff_sgn3_r  <= ff_sgn2_r;
      ff_nan3_r  <= ff_nan2_r;
      ff_big3_r  <= ff_big2_r;
      ff_zer3_r  <= ff_zer2_r;
      ff_mag3_r  <= ff_left2_r ? ff_val2_r : (ff_inc_c >> 1);
      tf_sgn3_r  <= tf_sgn2_r;
      tf_zer3_r  <= tf_zer2_r;
      tf_norm3_r <= tf_mag2_r << (5'd31 - tf_p2_r);
      tf_p3_r    <= tf_p2_r;
    end
  end

  // ---- stage 4: saturate / assemble
  logic        tf_inc_c;
  logic [24:0] tf_s25_c;
  logic [7:0]  tf_exp_c;
  logic [31:0] ff_word_r, tf_word_r;
  logic        ff_bad_r;

  assign tf_inc_c = tf_norm3_r[7] & ((|tf_norm3_r[6:0]) | tf_norm3_r[8]);
  assign tf_s25_c = {1'b0, tf_norm3_r[31:8]} + 25'(tf_inc_c);
  assign tf_exp_c = 8'(9'(tf_p3_r) + 9'(tf_s25_c[24]) + 9'(127 - FRAC_WIDTH));

  always_ff @(posedge clk) begin
    if (en) begin
      if (ff_nan3_r) begin
        ff_word_r <= '0;
        ff_bad_r  <= 1'b1;
      end else if (ff_zer3_r) begin
        ff_word_r <= '0;
        ff_bad_r  <= 1'b0;
      end else if (ff_sgn3_r) begin
        if (ff_big3_r || (ff_mag3_r > 33'h080000000)) begin
          ff_word_r <= 32'h80000000;
          ff_bad_r  <= 1'b1;
        end else begin
          ff_word_r <= 32'(33'd0 - ff_mag3_r);
          ff_bad_r  <= 1'b0;
        end
      end else begin
        if (ff_big3_r || (ff_mag3_r > 33'h07FFFFFFF)) begin
          ff_word_r <= 32'h7FFFFFFF;
          ff_bad_r  <= 1'b1;
        end else begin
          ff_word_r <= ff_mag3_r[31:0];
          ff_bad_r  <= 1'b0;
        end
      end
      if (tf_zer3_r) begin
        tf_word_r <= '0;
      end else begin
        tf_word_r <= {tf_sgn3_r, tf_exp_c,
                      tf_s25_c[24] ? 23'd0 : tf_s25_c[22:0]};
      end
    end
  end

  assign ff_word = ff_word_r;
  assign ff_bad  = ff_bad_r;
  assign tf_word = tf_word_r;

endmodule
